// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("clocked check failed");

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("check through reset failed");

`endif

// File: rtl/firlc_pkg.sv
// Constants and types of the loadable-coefficient FIR filter.
package firlc_pkg;

  localparam int TAP_SPREAD = 32;
  localparam int TAP_COUNT  = 2 * TAP_SPREAD + 1;
  localparam int TAP_IDX_W  = $clog2(TAP_COUNT);

  localparam int SMP_W   = 16;
  localparam int COEF_W  = 18;
  localparam int PROD_W  = SMP_W + COEF_W;
  localparam int ACC_W   = PROD_W + $clog2(TAP_COUNT);

  // request kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // valid and last flags of the operand pair presented to the MAC
  typedef struct packed {
    logic vld;
    logic last;
  } mac_op_t;

  // accumulator status and rounded result
  typedef struct packed {
    logic                    done;
    logic signed [SMP_W-1:0] value;
    logic                    sat;
  } mac_res_t;

endpackage

// File: rtl/firlc_mac.sv
// Multiply-accumulate with Q.31 to Q1.15 rounding and saturation.
module firlc_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clr,
  input  firlc_pkg::mac_op_t                   op,
  input  logic signed [firlc_pkg::COEF_W-1:0]  coef,
  input  logic signed [firlc_pkg::SMP_W-1:0]   smp,
  output firlc_pkg::mac_res_t                  res
);

  firlc_pkg::mac_op_t                         prod_op;
  logic signed [firlc_pkg::PROD_W-1:0]        prod;
  logic signed [firlc_pkg::ACC_W-1:0]         acc;
  logic                                       done;
  logic signed [firlc_pkg::ACC_W:0]           rnd_sum;
  logic signed [firlc_pkg::ACC_W-16:0]        rnd_q;

  // product register
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      prod_op <= '0;
    end else begin
      prod_op <= op;
    end
    prod <= coef * smp;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      acc  <= '0;
      done <= 1'b0;
    end else if (prod_op.vld) begin
      acc <= acc + firlc_pkg::ACC_W'(prod);
      if (prod_op.last) begin
        done <= 1'b1;
      end
    end
  end

  // round half up: floor((acc + 2^15) / 2^16)
  assign rnd_sum = (firlc_pkg::ACC_W+1)'(acc) + (firlc_pkg::ACC_W+1)'(32768);
  assign rnd_q   = rnd_sum[firlc_pkg::ACC_W:16];

  always_comb begin
    res.done = done;
    priority if (rnd_q > (firlc_pkg::ACC_W-15)'(32767)) begin
      res.value = 16'sh7fff;
      res.sat   = 1'b1;
    end else if (rnd_q < -(firlc_pkg::ACC_W-15)'(32768)) begin
      res.value = 16'sh8000;
      res.sat   = 1'b1;
    end else begin
      res.value = rnd_q[firlc_pkg::SMP_W-1:0];
      res.sat   = 1'b0;
    end
  end

endmodule

// File: rtl/fir_filter_loadable_coefficients_unit.sv
// Top level of the direct-form FIR filter with loadable coefficients.
//
// Input channel (in_valid / in_ready) carries two kinds of request.
//   kind = coefficient write: coef_value is stored at tap coef_index; an
//     index beyond the last tap is dropped. No result follows.
//   kind = sample: sample_in enters the delay line at tap 0 and one result
//     request (sample_out, saturated, last_out) follows on the output channel.
// A sample is summed tap by tap: the delay line and coefficient store sit
// in synchronous RAMs (one read, one write port) and one shared MAC
// consumes one tap per cycle, plus read, multiply and accumulate stages.
// in_ready is low from a sample's acceptance until its result is loaded,
// so a sample is taken only once the previous sample's result is loaded.
// The delay line is a circular buffer: no data moves, a write pointer
// advances by one tap per sample.
// Reset clears the control state and the per-entry valid bits, so both
// stores read as zero until written; no clearing pass is needed.
// A stalled receiver: the result waits in the output register, and new
// requests are still taken. A following sample is summed but parks before
// the output until the pending result has gone.
module fir_filter_loadable_coefficients_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic signed [15:0]                   sample_in,
  input  logic [6:0]                           coef_index,
  input  logic signed [17:0]                   coef_value,
  input  logic                                 last_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   sample_out,
  output logic                                 saturated,
  output logic                                 last_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  localparam logic [firlc_pkg::TAP_IDX_W-1:0] LAST_TAP =
    firlc_pkg::TAP_IDX_W'(firlc_pkg::TAP_COUNT - 1);

  logic [1:0]                                  state;
  logic [firlc_pkg::TAP_IDX_W-1:0]             cnt;
  logic [firlc_pkg::TAP_IDX_W-1:0]             wr_ptr;
  logic [firlc_pkg::TAP_IDX_W-1:0]             rd_ptr;
  logic                                        last_hold;

  logic                                        accept;
  logic                                        smp_wr;
  logic                                        coef_wr;
  logic                                        issue;
  logic                                        out_load;
  logic [firlc_pkg::TAP_IDX_W-1:0]             coef_wa;

  // storage
  logic signed [firlc_pkg::COEF_W-1:0]         coef_mem [firlc_pkg::TAP_COUNT];
  logic signed [firlc_pkg::SMP_W-1:0]          dly_mem  [firlc_pkg::TAP_COUNT];
  logic [firlc_pkg::TAP_COUNT-1:0]             coef_vld;
  logic [firlc_pkg::TAP_COUNT-1:0]             dly_vld;

  // read stage
  logic signed [firlc_pkg::COEF_W-1:0]         coef_q;
  logic signed [firlc_pkg::SMP_W-1:0]          dly_q;
  logic                                        coef_vq;
  logic                                        dly_vq;
  firlc_pkg::mac_op_t                          rd_op;
  logic signed [firlc_pkg::COEF_W-1:0]         coef_op;
  logic signed [firlc_pkg::SMP_W-1:0]          dly_op;
  firlc_pkg::mac_res_t                         mac_res;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign smp_wr   = accept && (kind == firlc_pkg::KIND_SAMPLE);
  assign coef_wr  = accept && (kind == firlc_pkg::KIND_COEF) &&
                    (32'(coef_index) < 32'(firlc_pkg::TAP_COUNT));
  assign coef_wa  = firlc_pkg::TAP_IDX_W'(coef_index);
  assign issue    = (state == ST_RUN);
  assign out_load = (state == ST_WAIT) && mac_res.done && (!out_valid || out_ready);

  // Writes happen only on acceptance, i.e. in idle, so they never meet a
  // read of the summing pass: no forwarding needed.
  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[coef_wa] <= coef_value;
    end
    coef_q <= coef_mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (smp_wr) begin
      dly_mem[wr_ptr] <= sample_in;
    end
    dly_q <= dly_mem[rd_ptr];
  end

  // valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      dly_vld  <= '0;
    end else begin
      if (coef_wr) begin
        coef_vld[coef_wa] <= 1'b1;
      end
      if (smp_wr) begin
        dly_vld[wr_ptr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    coef_vq <= coef_vld[cnt];
    dly_vq  <= dly_vld[rd_ptr];
  end

  assign coef_op = coef_vq ? coef_q : '0;
  assign dly_op  = dly_vq ? dly_q : '0;

  // sequencer: tap k pairs coefficient k with the sample k steps old
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      rd_op  <= '0;
    end else begin
      rd_op.vld  <= issue;
      rd_op.last <= issue && (cnt == LAST_TAP);
      unique case (state)
        ST_IDLE: begin
          if (smp_wr) begin
            state  <= ST_RUN;
            cnt    <= '0;
            rd_ptr <= wr_ptr;
            wr_ptr <= (wr_ptr == LAST_TAP) ? '0 : wr_ptr + 1'b1;
          end
        end
        ST_RUN: begin
          rd_ptr <= (rd_ptr == '0) ? LAST_TAP : rd_ptr - 1'b1;
          if (cnt == LAST_TAP) begin
            state <= ST_WAIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_WAIT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (smp_wr) begin
      last_hold <= last_in;
    end
  end

  firlc_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .clr  (smp_wr),
    .op   (rd_op),
    .coef (coef_op),
    .smp  (dly_op),
    .res  (mac_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= mac_res.value;
      saturated  <= mac_res.sat;
      last_out   <= last_hold;
    end
  end

endmodule

// File: rtl/firlc_checker.sv
// Port-level checks for the FIR filter top level, bound to it.
`include "assert_macros.svh"

module firlc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] sample_out,
  input logic               saturated,
  input logic               last_out
);

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable({sample_out, saturated, last_out}))
  `ASSERT_CLK(a_sample_busy, in_valid && in_ready && !kind |=> !in_ready)
  `ASSERT_CLK(a_coef_quick, in_valid && in_ready && kind |=> in_ready)
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && in_ready)

endmodule

bind fir_filter_loadable_coefficients_unit firlc_checker u_firlc_checker (.*);
